// ===== design/ucs2eb_pkg.sv =====
// ----------------------------------------------------------------------------
// ucs2eb_pkg
// Shared types, constants and lookup functions of the UCS-2 escape encoder.
// ----------------------------------------------------------------------------
package ucs2eb_pkg;

  localparam int unsigned UnitW      = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [UnitW-1:0] ShiftLo  = 16'h0100;
  localparam logic [UnitW-1:0] ShiftHi  = 16'h0A00;
  localparam logic [UnitW-1:0] ShiftAdd = 16'hE000;
  localparam logic [ByteW-1:0] EscBase  = 8'h10;
  localparam logic [ByteW-1:0] LoAdj    = 8'd15;
  localparam logic [ByteW-1:0] HiAdj    = 8'd9;

  typedef enum logic [1:0] {
    BYTE_ESC = 2'd0,
    BYTE_LO  = 2'd1,
    BYTE_HI  = 2'd2
  } byte_pos_e;

  typedef struct packed {
    logic             hit;
    logic [ByteW-1:0] code;
  } special_t;

  // One classified code unit; a single-byte unit sends lo alone.
  typedef struct packed {
    logic             single;
    logic [ByteW-1:0] esc;
    logic [ByteW-1:0] lo;
    logic [ByteW-1:0] hi;
  } desc_t;

  function automatic special_t special_lookup(input logic [UnitW-1:0] cu);
    special_t r;
    r.hit = 1'b1;
    case (cu)
      16'h20AC: r.code = 8'h80;
      16'h201A: r.code = 8'h82;
      16'h0192: r.code = 8'h83;
      16'h201E: r.code = 8'h84;
      16'h2026: r.code = 8'h85;
      16'h2020: r.code = 8'h86;
      16'h2021: r.code = 8'h87;
      16'h02C6: r.code = 8'h88;
      16'h2030: r.code = 8'h89;
      16'h0160: r.code = 8'h8A;
      16'h2039: r.code = 8'h8B;
      16'h0152: r.code = 8'h8C;
      16'h017D: r.code = 8'h8E;
      16'h2018: r.code = 8'h91;
      16'h2019: r.code = 8'h92;
      16'h201C: r.code = 8'h93;
      16'h201D: r.code = 8'h94;
      16'h2022: r.code = 8'h95;
      16'h2013: r.code = 8'h96;
      16'h2014: r.code = 8'h97;
      16'h02DC: r.code = 8'h98;
      16'h2122: r.code = 8'h99;
      16'h0161: r.code = 8'h9A;
      16'h203A: r.code = 8'h9B;
      16'h0153: r.code = 8'h9C;
      16'h017E: r.code = 8'h9E;
      16'h0178: r.code = 8'h9F;
      default: begin
        r.hit  = 1'b0;
        r.code = '0;
      end
    endcase
    return r;
  endfunction

  function automatic logic is_reserved(input logic [ByteW-1:0] b);
    return b inside {8'hA4, 8'hA3, 8'hA7, 8'h24, 8'h5B, 8'h00, 8'h5C, 8'h20,
                     8'h0D, 8'h0A, 8'h22, 8'h7B, 8'h7D, 8'h40, 8'h80, 8'h7E,
                     8'h2F, 8'hBD, 8'h3B, 8'h5D, 8'h5F, 8'h3D, 8'h23};
  endfunction

endpackage

// ===== design/ucs2eb_front.sv =====
// ----------------------------------------------------------------------------
// ucs2eb_front
// Accept code units, classify them and register one descriptor per unit.
// ----------------------------------------------------------------------------
module ucs2eb_front
  import ucs2eb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [UnitW-1:0] in_unit_i,
  output logic             desc_valid_o,
  input  logic             desc_ready_i,
  output desc_t            desc_o
);

  logic             vld_q;
  desc_t            desc_q;
  desc_t            desc_d;
  special_t         sp;
  logic [UnitW-1:0] shifted;
  logic [ByteW-1:0] hi;
  logic [ByteW-1:0] lo;
  logic             hi_res;
  logic             lo_res;
  logic             accept;

  assign in_ready_o = !vld_q || desc_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    sp      = special_lookup(in_unit_i);
    shifted = (in_unit_i > ShiftLo && in_unit_i < ShiftHi) ? in_unit_i + ShiftAdd
                                                             : in_unit_i;
    hi      = shifted[UnitW-1:ByteW];
    lo      = shifted[ByteW-1:0];
    hi_res  = is_reserved(hi);
    lo_res  = is_reserved(lo);

    desc_d.single = sp.hit || (hi == '0);
    desc_d.esc    = EscBase + {6'd0, hi_res, lo_res};
    desc_d.hi     = hi_res ? hi - HiAdj : hi;
    if (sp.hit) begin
      desc_d.lo = sp.code;
    end else if (hi == '0) begin
      desc_d.lo = lo;
    end else begin
      desc_d.lo = lo_res ? lo + LoAdj : lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= desc_d;
    end
  end

  assign desc_valid_o = vld_q;
  assign desc_o       = desc_q;

endmodule

// ===== design/ucs2eb_queue.sv =====
// ----------------------------------------------------------------------------
// ucs2eb_queue
// Short descriptor queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module ucs2eb_queue
  import ucs2eb_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  desc_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output desc_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push;
  logic            pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/ucs2eb_back.sv =====
// ----------------------------------------------------------------------------
// ucs2eb_back
// Byte sequencer: send one or three bytes per descriptor through a register.
// ----------------------------------------------------------------------------
module ucs2eb_back
  import ucs2eb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             desc_valid_i,
  output logic             desc_ready_o,
  input  desc_t            desc_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             out_last_o
);

  byte_pos_e        pos_q;
  byte_pos_e        pos_d;
  logic             vld_q;
  logic [ByteW-1:0] byte_q;
  logic [ByteW-1:0] byte_d;
  logic             last_q;
  logic             last_d;
  logic             load;
  logic             emit;

  assign load = !vld_q || out_ready_i;
  assign emit = load && desc_valid_i;

  always_comb begin
    pos_d = pos_q;
    if (emit) begin
      if (last_d) begin
        pos_d = BYTE_ESC;
      end else if (pos_q == BYTE_ESC) begin
        pos_d = BYTE_LO;
      end else begin
        pos_d = BYTE_HI;
      end
    end
  end

  always_comb begin
    case (pos_q)
      BYTE_ESC: begin
        byte_d = desc_i.single ? desc_i.lo : desc_i.esc;
        last_d = desc_i.single;
      end
      BYTE_LO: begin
        byte_d = desc_i.lo;
        last_d = 1'b0;
      end
      BYTE_HI: begin
        byte_d = desc_i.hi;
        last_d = 1'b1;
      end
      default: begin
        byte_d = desc_i.hi;
        last_d = 1'b1;
      end
    endcase
  end

  assign desc_ready_o = emit && last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= BYTE_ESC;
      vld_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (load) begin
        vld_q <= desc_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

// ===== design/ucs2_escape_byte_encoder_top.sv =====
// ----------------------------------------------------------------------------
// ucs2_escape_byte_encoder_top
// UCS-2 code units in, CP1252 or escaped byte sequences out.
//
//   channel   direction  payload                       end marker
//   s_axis    in         tdata[15:0] code_unit          -
//   m_axis    out        tdata[7:0]  out_byte           tlast = last_byte
//
// One unit per cycle enters while bytes drain and the queue has room; the output
// sends one byte per cycle while the receiver is ready, three for an escaped
// unit, else one. Units pass the classifier register, queue and output
// register. The queue of QueueDepth descriptors decouples input stalls from
// output stalls. Reset is asynchronous, active low, and empties all stages.
// ----------------------------------------------------------------------------
module ucs2_escape_byte_encoder_top
  import ucs2eb_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [UnitW-1:0]         s_axis_tdata_i,   // [15:0] code_unit
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [ByteW-1:0]         m_axis_tdata_o,   // [7:0] out_byte
  output logic                     m_axis_tlast_o
);

  logic  fr_valid;
  logic  fr_ready;
  desc_t fr_desc;
  logic  bk_valid;
  logic  bk_ready;
  desc_t bk_desc;

  ucs2eb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_unit_i    (s_axis_tdata_i),
    .desc_valid_o (fr_valid),
    .desc_ready_i (fr_ready),
    .desc_o       (fr_desc)
  );

  ucs2eb_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_desc),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_desc)
  );

  ucs2eb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (bk_valid),
    .desc_ready_o (bk_ready),
    .desc_i       (bk_desc),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

// ===== design/ucs2eb_checker.sv =====
// ----------------------------------------------------------------------------
// ucs2eb_checker
// Port-level checks of the escape encoder's output byte framing.
// ----------------------------------------------------------------------------
module ucs2eb_checker
  import ucs2eb_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [ByteW-1:0] m_axis_tdata_o,
  input logic             m_axis_tlast_o
);

  logic       out_acc;
  logic [1:0] run_q;

  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 2'd0;
    end else if (out_acc) begin
      run_q <= m_axis_tlast_o ? 2'd0 : run_q + 2'd1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output changed while stalled");

  a_esc_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && run_q == 2'd0 && !m_axis_tlast_o |->
      m_axis_tdata_o[7:2] == 6'b000100)
    else $error("escape byte out of range");

  a_mid_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && run_q == 2'd1 |-> !m_axis_tlast_o)
    else $error("escape sequence ended after two bytes");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && run_q == 2'd2 |-> m_axis_tlast_o)
    else $error("escape sequence longer than three bytes");

endmodule

bind ucs2_escape_byte_encoder_top ucs2eb_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== tb/tb_ucs2_escape_byte_encoder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ucs2_escape_byte_encoder_top
// Self-checking bench for the UCS-2 escape byte encoder. A clocked driver
// sends code units from a queue filled by the stimulus process. Every
// accepted transaction is run through a local encoder model, which queues
// the expected output bytes. A clocked monitor compares each output byte and
// its tlast against the oldest expected byte. Both sides insert random idle
// cycles, except for one window with no idling. The receiver also holds off
// once for a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_ucs2_escape_byte_encoder_top;
  import ucs2eb_pkg::*;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [UnitW-1:0] s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [ByteW-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  logic [15:0] cp_unit_tab [27] = '{
    16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D, 16'h2018,
    16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h02DC,
    16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h017E, 16'h0178
  };
  logic [7:0] cp_byte_tab [27] = '{
    8'h80, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
    8'h8A, 8'h8B, 8'h8C, 8'h8E, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95,
    8'h96, 8'h97, 8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9E, 8'h9F
  };
  logic [7:0] rsv_tab [23] = '{
    8'hA4, 8'hA3, 8'hA7, 8'h24, 8'h5B, 8'h00, 8'h5C, 8'h20, 8'h0D, 8'h0A,
    8'h22, 8'h7B, 8'h7D, 8'h40, 8'h80, 8'h7E, 8'h2F, 8'hBD, 8'h3B, 8'h5D,
    8'h5F, 8'h3D, 8'h23
  };

  logic [15:0] unit_q [$];
  logic [7:0]  exp_byte_q [$];
  logic        exp_last_q [$];
  int          cycle_cnt = 0;
  int          hold_left = 0;
  int          err_cnt   = 0;

  ucs2_escape_byte_encoder_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic logic is_rsv_byte(input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    foreach (rsv_tab[i]) if (rsv_tab[i] == b) hit = 1'b1;
    return hit;
  endfunction

  // no idling inside the quiet window
  function automatic logic skip_cycle();
    if (cycle_cnt >= 800 && cycle_cnt < 1200) return 1'b0;
    return $urandom_range(99) < 33;
  endfunction

  function automatic logic [15:0] rand_unit();
    int          sel;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [15:0] u;
    sel = $urandom_range(99);
    hi  = 8'($urandom_range(255));
    lo  = 8'($urandom_range(255));
    if (sel < 20) begin
      u = cp_unit_tab[$urandom_range(26)];
    end else if (sel < 40) begin
      if ($urandom_range(1)) hi = rsv_tab[$urandom_range(22)];
      if ($urandom_range(1)) lo = rsv_tab[$urandom_range(22)];
      u = {hi, lo};
    end else if (sel < 55) begin
      u = 16'($urandom_range(16'h0AFF));
    end else if (sel < 65) begin
      u = {8'h00, lo};
    end else begin
      u = 16'($urandom_range(16'hFFFF));
    end
    return u;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    exp_byte_q.push_back(b);
    exp_last_q.push_back(last);
  endtask

  task automatic encode_unit(input logic [15:0] cu);
    logic [15:0] u;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  esc;
    logic        hit;
    logic [7:0]  code;
    hit  = 1'b0;
    code = '0;
    foreach (cp_unit_tab[i]) begin
      if (cp_unit_tab[i] == cu) begin
        hit  = 1'b1;
        code = cp_byte_tab[i];
      end
    end
    if (hit) begin
      push_byte(code, 1'b1);
    end else begin
      u = cu;
      if (cu > 16'h0100 && cu < 16'h0A00) u = cu + 16'hE000;
      hi = u[15:8];
      lo = u[7:0];
      if (hi == 8'h00) begin
        push_byte(lo, 1'b1);
      end else begin
        esc = 8'h10;
        if (is_rsv_byte(hi)) begin
          esc = esc + 8'd2;
          hi  = hi - 8'd9;
        end
        if (is_rsv_byte(lo)) begin
          esc = esc + 8'd1;
          lo  = lo + 8'd15;
        end
        push_byte(esc, 1'b0);
        push_byte(lo, 1'b0);
        push_byte(hi, 1'b1);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic check_byte(input logic [7:0] b, input logic last);
    logic [7:0] want_b;
    logic       want_last;
    if (exp_byte_q.size() == 0) begin
      $display("%0t: unexpected output byte %h", $time, b);
      err_cnt++;
    end else begin
      want_b    = exp_byte_q.pop_front();
      want_last = exp_last_q.pop_front();
      if (b !== want_b) report_mismatch("out_byte", b, want_b);
      if (last !== want_last) report_mismatch("last_byte", {7'd0, last}, {7'd0, want_last});
    end
  endtask

  // driver: advance on each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) encode_unit(s_axis_tdata);
      if (unit_q.size() != 0 && !skip_cycle()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= unit_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // hold off the receiver once for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (cycle_cnt == 300) begin
      hold_left <= 80;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: check accepted bytes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_byte(m_axis_tdata, m_axis_tlast);
      m_axis_tready <= (hold_left == 0) && !skip_cycle();
    end
  end

  initial begin
    logic [15:0] directed [] = '{
      16'h0000, 16'hFFFF, 16'h00FF, 16'h0080, 16'h0100, 16'h0101, 16'h09FF,
      16'h0A00, 16'h0A01, 16'h20AC, 16'h0178, 16'h0192, 16'h0160, 16'h2122,
      16'hA4A4, 16'h2341, 16'h4124, 16'hBD5F, 16'h5555, 16'hAAAA, 16'h00A4
    };
    foreach (directed[i]) unit_q.push_back(directed[i]);
    for (int i = 0; i < 500; i++) unit_q.push_back(rand_unit());
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (unit_q.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (exp_byte_q.size() != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
